// ===== rtl/vfce_pkg.sv =====
// Shared types, constants and helpers of the voxel face cull emitter.
`default_nettype none

package vfce_pkg;

  // Chunk geometry
  localparam int CHUNK_WIDTH  = 16;
  localparam int CHUNK_HEIGHT = 128;
  localparam int SIDE_CELLS   = CHUNK_WIDTH + 2;
  localparam int STORE_DEPTH  = SIDE_CELLS * CHUNK_HEIGHT * SIDE_CELLS;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);

  // Item command codes
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_MESH  = 1'b1;

  // Block ids
  localparam logic [7:0] ID_GRASS = 8'd1;
  localparam logic [7:0] ID_STONE = 8'd2;

  // Atlas tiles
  localparam logic [7:0] TILE_GRASS_TOP    = 8'd0;
  localparam logic [7:0] TILE_GRASS_SIDE   = 8'd1;
  localparam logic [7:0] TILE_GRASS_BOTTOM = 8'd2;
  localparam logic [7:0] TILE_STONE        = 8'd3;

  // Face directions
  localparam logic [2:0] FACE_NEG_X = 3'd0;
  localparam logic [2:0] FACE_POS_X = 3'd1;
  localparam logic [2:0] FACE_NEG_Z = 3'd2;
  localparam logic [2:0] FACE_POS_Z = 3'd3;
  localparam logic [2:0] FACE_NEG_Y = 3'd4;
  localparam logic [2:0] FACE_POS_Y = 3'd5;
  localparam int         NUM_FACES  = 6;

  // Read selects: the centre cell, then one per face direction (face + 1)
  localparam logic [2:0] SEL_CENTRE = 3'd0;
  localparam logic [2:0] SEL_NEG_X  = 3'd1;
  localparam logic [2:0] SEL_POS_X  = 3'd2;
  localparam logic [2:0] SEL_NEG_Z  = 3'd3;
  localparam logic [2:0] SEL_POS_Z  = 3'd4;
  localparam logic [2:0] SEL_NEG_Y  = 3'd5;
  localparam logic [2:0] SEL_POS_Y  = 3'd6;

  typedef struct packed {
    logic       command;
    logic [4:0] pos_x;
    logic [6:0] pos_y;
    logic [4:0] pos_z;
    logic [7:0] block_id;
  } in_item_t;

  typedef struct packed {
    logic [3:0] local_x;
    logic [6:0] local_y;
    logic [3:0] local_z;
    logic [2:0] face_dir;
    logic [7:0] atlas_tile;
    logic       last_face;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic       latch;
    logic       wr;
    logic       rd;
    logic [2:0] rd_sel;
    logic       emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cmd_store;
    logic store_ok;
    logic mesh_ok;
    logic centre_full;
    logic rem_any;
    logic rem_one;
    logic out_free;
  } sts_t;

  function automatic logic is_full(input logic [7:0] id);
    return (id == ID_GRASS) || (id == ID_STONE);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vfce_ctrl.sv =====
// Sequencing state machine: store write, seven reads, face emission.
`default_nettype none

module vfce_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  vfce_pkg::sts_t sts_i,
  output vfce_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] cnt_q, cnt_d;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.rd_sel  = vfce_pkg::SEL_CENTRE;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_START;
        end
      end
      ST_START: begin
        if (sts_i.cmd_store) begin
          cmd_o.wr = sts_i.store_ok;
          state_d  = ST_IDLE;
        end else if (sts_i.mesh_ok) begin
          cmd_o.rd     = 1'b1;
          cmd_o.rd_sel = vfce_pkg::SEL_CENTRE;
          cnt_d        = vfce_pkg::SEL_NEG_X;
          state_d      = ST_READ;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd_o.rd     = 1'b1;
        cmd_o.rd_sel = cnt_q;
        cnt_d        = cnt_q + 3'd1;
        if (cnt_q == vfce_pkg::SEL_POS_Y) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last neighbour lands in the mask this cycle
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts_i.centre_full || !sts_i.rem_any) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.rem_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= vfce_pkg::SEL_CENTRE;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vfce_datapath.sv =====
// Item registers, block store, neighbour mask and output register.
`default_nettype none

module vfce_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vfce_pkg::in_item_t  in_data_i,
  input  vfce_pkg::cmd_t      cmd_i,
  output vfce_pkg::sts_t      sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vfce_pkg::out_item_t out_data_o
);

  localparam int AW = vfce_pkg::ADDR_W;

  vfce_pkg::in_item_t  item_q;
  vfce_pkg::out_item_t out_q;
  logic                out_valid_q;

  logic [7:0]    mem_q [vfce_pkg::STORE_DEPTH];
  logic [7:0]    rdata_q;
  logic [2:0]    tag_q;
  logic          tag_vld_q;
  logic          oob_q;
  logic [7:0]    id_q;
  logic [vfce_pkg::NUM_FACES-1:0] mask_q;

  logic [4:0]    ax, az;
  logic [6:0]    ay;
  logic          y_oob;
  logic [AW-1:0] col;
  logic [AW-1:0] addr;
  logic [2:0]    dir_sel;
  logic [7:0]    tile;
  logic          last;

  // Coordinates of the selected cell; heights off the chunk read as air
  always_comb begin
    ax    = item_q.pos_x;
    ay    = item_q.pos_y;
    az    = item_q.pos_z;
    y_oob = 1'b0;
    case (cmd_i.rd_sel)
      vfce_pkg::SEL_CENTRE: ;
      vfce_pkg::SEL_NEG_X:  ax = item_q.pos_x - 5'd1;
      vfce_pkg::SEL_POS_X:  ax = item_q.pos_x + 5'd1;
      vfce_pkg::SEL_NEG_Z:  az = item_q.pos_z - 5'd1;
      vfce_pkg::SEL_POS_Z:  az = item_q.pos_z + 5'd1;
      vfce_pkg::SEL_NEG_Y: begin
        ay    = item_q.pos_y - 7'd1;
        y_oob = (item_q.pos_y == 7'd0);
      end
      vfce_pkg::SEL_POS_Y: begin
        ay    = item_q.pos_y + 7'd1;
        y_oob = (32'(item_q.pos_y) >= vfce_pkg::CHUNK_HEIGHT - 1);
      end
      default: ;
    endcase
  end

  assign col  = AW'(ax) * AW'(vfce_pkg::CHUNK_HEIGHT) + AW'(ay);
  assign addr = col * AW'(vfce_pkg::SIDE_CELLS) + AW'(az);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[addr] <= item_q.block_id;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_vld_q <= 1'b0;
    end else begin
      tag_vld_q <= cmd_i.rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_data_i;
    end
    if (cmd_i.rd) begin
      tag_q <= cmd_i.rd_sel;
      oob_q <= y_oob;
    end
    if (tag_vld_q) begin
      if (tag_q == vfce_pkg::SEL_CENTRE) begin
        id_q <= rdata_q;
      end else begin
        mask_q[3'(tag_q - 3'd1)] <= oob_q || !vfce_pkg::is_full(rdata_q);
      end
    end
    if (cmd_i.emit) begin
      mask_q[dir_sel] <= 1'b0;
    end
  end

  // Lowest pending face goes first
  always_comb begin
    dir_sel = vfce_pkg::FACE_NEG_X;
    for (int i = vfce_pkg::NUM_FACES - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        dir_sel = 3'(i);
      end
    end
  end

  assign last = ((mask_q & (mask_q - 6'd1)) == 6'd0);

  always_comb begin
    if (id_q == vfce_pkg::ID_STONE) begin
      tile = vfce_pkg::TILE_STONE;
    end else if (dir_sel == vfce_pkg::FACE_POS_Y) begin
      tile = vfce_pkg::TILE_GRASS_TOP;
    end else if (dir_sel == vfce_pkg::FACE_NEG_Y) begin
      tile = vfce_pkg::TILE_GRASS_BOTTOM;
    end else begin
      tile = vfce_pkg::TILE_GRASS_SIDE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.local_x    <= 4'(item_q.pos_x - 5'd1);
      out_q.local_y    <= item_q.pos_y;
      out_q.local_z    <= 4'(item_q.pos_z - 5'd1);
      out_q.face_dir   <= dir_sel;
      out_q.atlas_tile <= tile;
      out_q.last_face  <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.cmd_store   = (item_q.command == vfce_pkg::CMD_STORE);
  assign sts_o.store_ok    = (32'(item_q.pos_x) < vfce_pkg::SIDE_CELLS) &&
                             (32'(item_q.pos_z) < vfce_pkg::SIDE_CELLS) &&
                             (32'(item_q.pos_y) < vfce_pkg::CHUNK_HEIGHT);
  assign sts_o.mesh_ok     = (item_q.pos_x != 5'd0) && (item_q.pos_z != 5'd0) &&
                             (32'(item_q.pos_x) <= vfce_pkg::CHUNK_WIDTH) &&
                             (32'(item_q.pos_z) <= vfce_pkg::CHUNK_WIDTH) &&
                             (32'(item_q.pos_y) < vfce_pkg::CHUNK_HEIGHT);
  assign sts_o.centre_full = vfce_pkg::is_full(id_q);
  assign sts_o.rem_any     = (mask_q != 6'd0);
  assign sts_o.rem_one     = (mask_q != 6'd0) && last;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// ===== rtl/voxel_face_cull_emitter.sv =====
// Top level of the voxel face cull emitter: controller plus datapath.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o  | vfce_pkg::in_item_t  in_data_i
//   out     | output    | out_valid_o / out_ready_i| vfce_pkg::out_item_t out_data_o
//
// Store item: accept, then write. Mesh item outside the interior: accept, then drop.
// Mesh item: seven reads of the single-port block store (centre then six
// neighbours), a drain step, then the visible faces of a solid centre in turn;
// each face waits while the output beat stalls.
// Emitted faces sit in an output register; a new item is taken while it waits.
// Reset clears control only; store contents are undefined until written,
// there is no clearing pass.
`default_nettype none

module voxel_face_cull_emitter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vfce_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vfce_pkg::out_item_t out_data_o
);

  vfce_pkg::cmd_t cmd;
  vfce_pkg::sts_t sts;

  vfce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vfce_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== rtl/vfce_checker.sv =====
// Port-level checks of the voxel face cull emitter and their bind.
`default_nettype none

module vfce_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input vfce_pkg::out_item_t out_data_o
);

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // Faces of one item follow each other without a gap
  a_face_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_face |=> out_valid_o)
    else $error("gap inside a face run");

  // Busy straight after taking an item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after an accepted beat");

  // Tile matches direction
  a_tile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.atlas_tile == vfce_pkg::TILE_STONE) ||
      (out_data_o.face_dir == vfce_pkg::FACE_POS_Y &&
       out_data_o.atlas_tile == vfce_pkg::TILE_GRASS_TOP) ||
      (out_data_o.face_dir == vfce_pkg::FACE_NEG_Y &&
       out_data_o.atlas_tile == vfce_pkg::TILE_GRASS_BOTTOM) ||
      (out_data_o.face_dir != vfce_pkg::FACE_POS_Y &&
       out_data_o.face_dir != vfce_pkg::FACE_NEG_Y &&
       out_data_o.face_dir <= vfce_pkg::FACE_POS_Y &&
       out_data_o.atlas_tile == vfce_pkg::TILE_GRASS_SIDE))
    else $error("atlas tile does not fit face direction");

endmodule

bind voxel_face_cull_emitter vfce_checker u_vfce_checker (.*);

`default_nettype wire
